### sv/dlrz_pkg.sv
// Shared types and constants for the DDA line rasteriser with depth store
`default_nettype none
package dlrz_pkg;

    localparam int unsigned SCREEN_W_DEF = 320;
    localparam int unsigned SCREEN_H_DEF = 240;

    localparam logic [31:0] CYAN_COLOR = 32'hFF00FFFF;
    localparam logic [23:0] DEPTH_MAX  = 24'hFFFFFF;

    // divider: |d| * 2^16 + steps/2 over steps
    localparam int DIV_NW = 41;
    localparam int DIV_DW = 21;

    localparam logic OP_START   = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    typedef struct packed {
        logic               opcode;
        logic signed [19:0] start_x;
        logic signed [19:0] start_y;
        logic        [23:0] start_z;
        logic signed [19:0] end_x;
        logic signed [19:0] end_y;
        logic        [23:0] end_z;
        logic        [7:0]  red;
        logic        [7:0]  green;
        logic        [7:0]  blue;
        logic               depth_enable;
    } t_in_item;

    typedef struct packed {
        logic        pixel_valid;
        logic [8:0]  pixel_x;
        logic [7:0]  pixel_y;
        logic [31:0] pixel_color;
        logic        line_done;
    } t_out_item;

    typedef struct packed {
        logic       capture;
        logic       load;
        logic       div_go;
        logic       div_store;
        logic [1:0] div_sel;
        logic       adv0;
        logic       adv1;
        logic       adv2;
        logic       emit_zero;
        logic       clr;
    } t_cmd;

    typedef struct packed {
        logic in_start;
        logic line_idle;
        logic div_done;
        logic out_free;
        logic clr_last;
    } t_status;

endpackage
`default_nettype wire

### sv/dlrz_div.sv
// Restoring divider, one quotient bit per cycle
`default_nettype none
module dlrz_div (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [dlrz_pkg::DIV_NW-1:0]  i_num,
    input  wire logic [dlrz_pkg::DIV_DW-1:0]  i_den,
    output logic      [dlrz_pkg::DIV_NW-1:0]  o_quo,
    output logic                              o_done
);
    import dlrz_pkg::*;

    logic              r_busy, r_done;
    logic [5:0]        r_cnt;
    logic [DIV_NW-1:0] r_quo;
    logic [DIV_DW-1:0] r_rem, r_den;
    logic [DIV_DW:0]   shifted, diff;
    logic              ge;

    always_comb begin
        shifted = {r_rem, r_quo[DIV_NW-1]};
        diff    = shifted - {1'b0, r_den};
        ge      = shifted >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'(DIV_NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_NW-2:0], ge};
            r_rem <= ge ? diff[DIV_DW-1:0] : shifted[DIV_DW-1:0];
        end
    end

    assign o_quo  = r_quo;
    assign o_done = r_done;
endmodule
`default_nettype wire

### sv/dlrz_datapath.sv
// Line set-up, cursor stepping, depth store and output register
`default_nettype none
module dlrz_datapath #(
    parameter int unsigned SCREEN_WIDTH  = dlrz_pkg::SCREEN_W_DEF,
    parameter int unsigned SCREEN_HEIGHT = dlrz_pkg::SCREEN_H_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire dlrz_pkg::t_in_item  i_in_data,
    input  wire dlrz_pkg::t_cmd      i_cmd,
    output dlrz_pkg::t_status        o_status,
    output dlrz_pkg::t_out_item      o_out_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall
);
    import dlrz_pkg::*;

    localparam int unsigned DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int AW = $clog2(DEPTH);
    localparam int XW = $clog2(SCREEN_WIDTH);
    localparam int YW = $clog2(SCREEN_HEIGHT);

    t_in_item           r_in;
    logic signed [21:0] r_dx, r_dy;
    logic signed [24:0] r_dz;
    logic [20:0]        r_steps;
    logic signed [31:0] r_cx, r_cy, r_stx, r_sty;
    logic signed [43:0] r_cz;
    logic signed [40:0] r_stz;
    logic [12:0]        r_left;
    logic [31:0]        r_color;
    logic               r_depth_on;
    logic [15:0]        r_px, r_py;
    logic               r_inb;
    logic [23:0]        r_z, r_rd;
    logic [AW-1:0]      r_addr, r_clr_cnt;
    logic               r_out_valid;
    t_out_item          r_out;
    logic [23:0]        mem [DEPTH];

    // set-up
    logic signed [20:0] vsx, vex, sx, ex;
    logic signed [21:0] dx, dy, adx, ady;
    logic signed [24:0] dz;
    logic [20:0]        steps;
    logic [21:0]        steps_rnd;
    always_comb begin
        vsx = {r_in.start_x[19], r_in.start_x};
        vex = {r_in.end_x[19], r_in.end_x};
        sx  = (vsx[7:0] != 8'd0) ? {vsx[20:8], 8'd0} + 21'sd256 : vsx;
        ex  = (vex[7:0] != 8'd0) ? {vex[20:8], 8'd0} + 21'sd256 : vex;
        dx  = {ex[20], ex} - {sx[20], sx};
        dy  = {{2{r_in.end_y[19]}}, r_in.end_y} - {{2{r_in.start_y[19]}}, r_in.start_y};
        dz  = {1'b0, r_in.end_z} - {1'b0, r_in.start_z};
        adx = dx[21] ? -dx : dx;
        ady = dy[21] ? -dy : dy;
        steps = (adx > ady) ? adx[20:0] : ady[20:0];
        steps_rnd = {1'b0, steps} + 22'd255;
    end

    // divider operands
    logic [23:0]       mag;
    logic              neg;
    logic [DIV_NW-1:0] num, quo;
    logic              div_done;
    logic signed [31:0] q32;
    always_comb begin
        case (i_cmd.div_sel)
            2'd0:    begin mag = r_dx[21] ? 24'(-r_dx) : 24'(r_dx); neg = r_dx[21]; end
            2'd1:    begin mag = r_dy[21] ? 24'(-r_dy) : 24'(r_dy); neg = r_dy[21]; end
            default: begin mag = r_dz[24] ? 24'(-r_dz) : 24'(r_dz); neg = r_dz[24]; end
        endcase
        num = DIV_NW'({mag, 16'd0}) + DIV_NW'(r_steps >> 1);
        q32 = neg ? -32'(quo) : 32'(quo);
    end

    dlrz_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_go),
        .i_num   (num),
        .i_den   (r_steps),
        .o_quo   (quo),
        .o_done  (div_done)
    );

    // pixel rounding
    logic [31:0] sumx, sumy;
    logic [43:0] sumz;
    logic [15:0] px, py;
    logic [23:0] zpix;
    always_comb begin
        sumx = {1'b0, r_cx[30:0]} + 32'd32768;
        sumy = {1'b0, r_cy[30:0]} + 32'd32768;
        px   = sumx[31:16];
        py   = sumy[31:16];
        sumz = {1'b0, r_cz[42:0]} + 44'd128;
        if (r_cz[43])
            zpix = '0;
        else if (|sumz[43:32])
            zpix = DEPTH_MAX;
        else
            zpix = sumz[31:8];
    end

    logic [AW-1:0] addr;
    logic          wr, mem_we;
    always_comb begin
        addr = AW'(r_px[XW-1:0]) + AW'(r_py[YW-1:0] * SCREEN_WIDTH);
        if (!r_inb)
            wr = 1'b0;
        else if (!r_depth_on)
            wr = 1'b1;
        else if (r_color == CYAN_COLOR)
            wr = (r_rd == 24'd0);
        else
            wr = (r_z > r_rd);
        mem_we = i_cmd.adv2 && wr && r_depth_on;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr)
            mem[r_clr_cnt] <= '0;
        else if (mem_we)
            mem[r_addr] <= r_z;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.adv1)
            r_rd <= mem[addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left      <= '0;
            r_clr_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr)
                r_clr_cnt <= r_clr_cnt + AW'(1);
            if (i_cmd.load)
                r_left <= 13'(steps_rnd >> 8) + 13'd1;
            else if (i_cmd.adv2)
                r_left <= r_left - 13'd1;
            if (i_cmd.adv2 || i_cmd.emit_zero)
                r_out_valid <= 1'b1;
            else if (!i_out_stall)
                r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture)
            r_in <= i_in_data;
        if (i_cmd.load) begin
            r_dx       <= dx;
            r_dy       <= dy;
            r_dz       <= dz;
            r_steps    <= steps;
            r_cx       <= {{3{sx[20]}}, sx, 8'd0};
            r_cy       <= {{4{r_in.start_y[19]}}, r_in.start_y, 8'd0};
            r_cz       <= {12'd0, r_in.start_z, 8'd0};
            r_color    <= {8'hFF, r_in.red, r_in.green, r_in.blue};
            r_depth_on <= r_in.depth_enable;
        end
        if (i_cmd.div_store) begin
            case (i_cmd.div_sel)
                2'd0:    r_stx <= (r_steps == '0) ? '0 : q32;
                2'd1:    r_sty <= (r_steps == '0) ? '0 : q32;
                default: r_stz <= (r_steps == '0) ? '0
                                  : (neg ? -{1'b0, quo[39:0]} : {1'b0, quo[39:0]});
            endcase
        end
        if (i_cmd.adv0) begin
            r_px  <= px;
            r_py  <= py;
            r_z   <= zpix;
            r_inb <= !r_cx[31] && !r_cy[31] && px != 16'd0 && py != 16'd0
                     && px < 16'(SCREEN_WIDTH) && py < 16'(SCREEN_HEIGHT);
        end
        if (i_cmd.adv1)
            r_addr <= addr;
        if (i_cmd.adv2) begin
            r_cx <= r_cx + r_stx;
            r_cy <= r_cy + r_sty;
            r_cz <= r_cz + {{3{r_stz[40]}}, r_stz};
            r_out.pixel_valid <= wr;
            r_out.pixel_x     <= wr ? r_px[8:0] : 9'd0;
            r_out.pixel_y     <= wr ? r_py[7:0] : 8'd0;
            r_out.pixel_color <= wr ? r_color : 32'd0;
            r_out.line_done   <= (r_left == 13'd1);
        end else if (i_cmd.emit_zero) begin
            r_out <= '0;
        end
    end

    always_comb begin
        o_status.in_start  = (i_in_data.opcode == OP_START);
        o_status.line_idle = (r_left == '0);
        o_status.div_done  = div_done;
        o_status.out_free  = !r_out_valid || !i_out_stall;
        o_status.clr_last  = (r_clr_cnt == AW'(DEPTH - 1));
    end

    assign o_out_data  = r_out;
    assign o_out_valid = r_out_valid;
endmodule
`default_nettype wire

### sv/dlrz_ctrl.sv
// Sequencer for clearing pass, line set-up and pixel steps
`default_nettype none
module dlrz_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire dlrz_pkg::t_status i_status,
    output dlrz_pkg::t_cmd         o_cmd
);
    import dlrz_pkg::*;

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_LOAD  = 4'd2;
    localparam logic [3:0] S_DIVGO = 4'd3;
    localparam logic [3:0] S_DIVWT = 4'd4;
    localparam logic [3:0] S_FIN   = 4'd5;
    localparam logic [3:0] S_ADV0  = 4'd6;
    localparam logic [3:0] S_ADV1  = 4'd7;
    localparam logic [3:0] S_ADV2  = 4'd8;
    localparam logic [3:0] S_NOP   = 4'd9;

    logic [3:0] r_state, n_state;
    logic [1:0] r_sel, n_sel;

    always_comb begin
        n_state = r_state;
        n_sel   = r_sel;
        o_cmd   = '0;
        o_cmd.div_sel = r_sel;
        case (r_state)
            S_CLR: begin
                o_cmd.clr = 1'b1;
                if (i_status.clr_last)
                    n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    if (i_status.in_start)
                        n_state = S_LOAD;
                    else if (i_status.line_idle)
                        n_state = S_NOP;
                    else
                        n_state = S_ADV0;
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_sel      = 2'd0;
                n_state    = S_DIVGO;
            end
            S_DIVGO: begin
                o_cmd.div_go = 1'b1;
                n_state      = S_DIVWT;
            end
            S_DIVWT: begin
                if (i_status.div_done) begin
                    o_cmd.div_store = 1'b1;
                    if (r_sel == 2'd2) begin
                        n_sel   = 2'd0;
                        n_state = S_FIN;
                    end else begin
                        n_sel   = r_sel + 2'd1;
                        n_state = S_DIVGO;
                    end
                end
            end
            S_FIN, S_NOP: begin
                if (i_status.out_free) begin
                    o_cmd.emit_zero = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_ADV0: begin
                o_cmd.adv0 = 1'b1;
                n_state    = S_ADV1;
            end
            S_ADV1: begin
                o_cmd.adv1 = 1'b1;
                n_state    = S_ADV2;
            end
            S_ADV2: begin
                if (i_status.out_free) begin
                    o_cmd.adv2 = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_sel   <= '0;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

`ifndef SYNTHESIS
    a_clr_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CLR |-> o_in_stall)
        else $error("input taken during clearing pass");
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.adv2 || o_cmd.emit_zero) |-> i_status.out_free)
        else $error("result loaded into occupied output register");
    a_adv_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_ADV1 |=> r_state == S_ADV2)
        else $error("pixel step sequence broken");
    a_sel_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_go |-> r_sel != 2'd3)
        else $error("divide select out of range");
`endif
endmodule
`default_nettype wire

### sv/dda_line_raster_zbuffer.sv
// Top level: DDA line rasteriser with depth store
//
//  channel | dir | handshake           | payload
//  in      | in  | i_in_valid/o_in_stall   | t_in_item  (start or advance)
//  out     | out | o_out_valid/i_out_stall | t_out_item (one per input transfer)
//
// After reset a clearing pass zeroes the depth store, one entry per cycle
// (SCREEN_WIDTH*SCREEN_HEIGHT entries, 76800 by default); no input is taken then.
// Start: the shared bit-serial divider gives the x, y and z steps in turn.
// Advance: states ADV0, ADV1 and ADV2 do the depth store read-compare-write.
// One item at a time; the output register holds a result under stall.
`default_nettype none
module dda_line_raster_zbuffer #(
    parameter int unsigned SCREEN_WIDTH  = dlrz_pkg::SCREEN_W_DEF,
    parameter int unsigned SCREEN_HEIGHT = dlrz_pkg::SCREEN_H_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire dlrz_pkg::t_in_item  i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output dlrz_pkg::t_out_item      o_out_data
);
    import dlrz_pkg::*;

    t_cmd    cmd;
    t_status status;

    dlrz_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    dlrz_datapath #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_data  (o_out_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall)
    );
endmodule
`default_nettype wire
